// ----- rtl/core/mer_pkg.sv -----
package mer_pkg;

   localparam int COORD_MAX  = 1023;
   localparam int RADIUS_MAX = 511;

   localparam int CENTER_W   = 10;
   localparam int RADIUS_W   = 9;
   localparam int POS_X_W    = 10;
   localparam int POS_Y_W    = 11;
   localparam int POINT_W    = 12;
   localparam int SQ_W       = 2 * RADIUS_W;
   localparam int TT_W       = 2 * (POS_X_W + 1);
   localparam int MUL_A_W    = TT_W;
   localparam int MUL_B_W    = SQ_W;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int TERM_W     = 32;
   localparam int DEC_W      = 42;
   localparam int BEAT_W     = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 2 * POINT_W;

   localparam logic REQ_BEGIN = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_RX2,
      MUL_RY2,
      MUL_RX2RY,
      MUL_TT,
      MUL_YY,
      MUL_TTRY2,
      MUL_YYRX2,
      MUL_RX2RY2
   } mul_op_type;

   typedef enum logic [2:0] {
      DEC_NONE,
      DEC_INIT,
      DEC_LOAD,
      DEC_ADD4,
      DEC_SUB4
   } dec_op_type;

   typedef struct packed {
      logic              load_geom;
      mul_op_type        mul_op;
      dec_op_type        dec_op;
      logic              step;
      logic              step_x;
      logic              step_y;
      logic              step_rx2;
      logic              load_beat;
      logic [BEAT_W-1:0] beat;
      logic              load_done;
   } dp_cmd_type;

   typedef struct packed {
      logic y_pos;
      logic y_neg;
      logic r1_below;
      logic dec_neg;
      logic dec_zero;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/core/mer_ctrl.sv -----
module mer_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_type,
   input  mer_pkg::dp_status_type status,
   output mer_pkg::dp_cmd_type    cmd
);

   typedef enum logic [13:0] {
      S_IDLE = 14'b00000000000001,
      S_B1   = 14'b00000000000010,
      S_B2   = 14'b00000000000100,
      S_B3   = 14'b00000000001000,
      S_B4   = 14'b00000000010000,
      S_T1   = 14'b00000000100000,
      S_T2   = 14'b00000001000000,
      S_T3   = 14'b00000010000000,
      S_T4   = 14'b00000100000000,
      S_T5   = 14'b00001000000000,
      S_T6   = 14'b00010000000000,
      S_STEP = 14'b00100000000000,
      S_EMIT = 14'b01000000000000,
      S_DONE = 14'b10000000000000
   } state_type;

   typedef enum logic [2:0] {
      R_IDLE = 3'b001,
      R_ONE  = 3'b010,
      R_TWO  = 3'b100
   } region_type;

   state_type                    state_ff, state_in;
   region_type                   region_ff, region_in;
   logic [mer_pkg::BEAT_W-1:0]   beat_ff, beat_in;
   logic                         in_r2;
   logic                         dec_pos;

   assign in_r2   = (region_ff == R_TWO);
   assign dec_pos = !status.dec_neg && !status.dec_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         region_ff <= R_IDLE;
         beat_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         region_ff <= region_in;
         beat_ff   <= beat_in;
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.mul_op   = mer_pkg::MUL_NONE;
      cmd.dec_op   = mer_pkg::DEC_NONE;
      cmd.step_x   = in_r2 ? !dec_pos : 1'b1;
      cmd.step_y   = in_r2 ? 1'b1 : !status.dec_neg;
      cmd.step_rx2 = in_r2;
      cmd.beat     = beat_ff;
      state_in     = state_ff;
      region_in    = region_ff;
      beat_in      = beat_ff;
      req_tready   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
         end
         S_B1: begin
            cmd.mul_op = mer_pkg::MUL_RX2;
            state_in   = S_B2;
         end
         S_B2: begin
            cmd.mul_op = mer_pkg::MUL_RY2;
            state_in   = S_B3;
         end
         S_B3: begin
            cmd.mul_op = mer_pkg::MUL_RX2RY;
            state_in   = S_B4;
         end
         S_B4: begin
            cmd.dec_op = mer_pkg::DEC_INIT;
            state_in   = S_IDLE;
         end
         S_T1: begin
            cmd.mul_op = mer_pkg::MUL_TT;
            state_in   = S_T2;
         end
         S_T2: begin
            cmd.mul_op = mer_pkg::MUL_YY;
            state_in   = S_T3;
         end
         S_T3: begin
            cmd.mul_op = mer_pkg::MUL_TTRY2;
            state_in   = S_T4;
         end
         S_T4: begin
            cmd.dec_op = mer_pkg::DEC_LOAD;
            cmd.mul_op = mer_pkg::MUL_YYRX2;
            state_in   = S_T5;
         end
         S_T5: begin
            cmd.dec_op = mer_pkg::DEC_ADD4;
            cmd.mul_op = mer_pkg::MUL_RX2RY2;
            state_in   = S_T6;
         end
         S_T6: begin
            cmd.dec_op = mer_pkg::DEC_SUB4;
            region_in  = R_TWO;
            state_in   = S_STEP;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            beat_in  = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.load_beat = 1'b1;
               beat_in       = beat_ff + mer_pkg::BEAT_W'(1);
               if (&beat_ff) begin
                  req_tready = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (req_tvalid && req_tready) begin
         if (req_type == mer_pkg::REQ_BEGIN) begin
            cmd.load_geom = 1'b1;
            region_in     = R_ONE;
            state_in      = S_B1;
         end else begin
            unique case (region_ff)
               R_ONE: begin
                  if (status.y_pos && status.r1_below) begin
                     cmd.step = 1'b1;
                     beat_in  = '0;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_T1;
                  end
               end
               R_TWO: begin
                  if (status.y_neg) begin
                     region_in = R_IDLE;
                     state_in  = S_DONE;
                  end else begin
                     cmd.step = 1'b1;
                     beat_in  = '0;
                     state_in = S_EMIT;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
      end
   end

endmodule

// ----- rtl/core/mer_dpath.sv -----
module mer_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mer_pkg::dp_cmd_type                   cmd,
   output mer_pkg::dp_status_type                status,
   input  logic [mer_pkg::CENTER_W-1:0]          center_x,
   input  logic [mer_pkg::CENTER_W-1:0]          center_y,
   input  logic [mer_pkg::RADIUS_W-1:0]          radius_x,
   input  logic [mer_pkg::RADIUS_W-1:0]          radius_y,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic signed [mer_pkg::POINT_W-1:0]    point_x,
   output logic signed [mer_pkg::POINT_W-1:0]    point_y,
   output logic                                  done_res,
   output logic                                  last
);

   localparam int CW = mer_pkg::CENTER_W;
   localparam int RW = mer_pkg::RADIUS_W;
   localparam int XW = mer_pkg::POS_X_W;
   localparam int YW = mer_pkg::POS_Y_W;
   localparam int PW = mer_pkg::POINT_W;
   localparam int SW = mer_pkg::SQ_W;
   localparam int TW = mer_pkg::TERM_W;
   localparam int DW = mer_pkg::DEC_W;

   logic [CW-1:0]                  cx_ff, cy_ff;
   logic [RW-1:0]                  rx_ff, ry_ff;
   logic [SW-1:0]                  rx2_ff, ry2_ff, yy_ff;
   logic [mer_pkg::TT_W-1:0]       tt_ff;
   logic [mer_pkg::PROD_W-1:0]     prod_ff;
   logic [XW-1:0]                  pos_x_ff, hold_x_ff;
   logic signed [YW-1:0]           pos_y_ff, hold_y_ff;
   logic signed [TW-1:0]           px_ff, py_ff;
   logic signed [DW-1:0]           dec_ff;
   logic                           pend_valid_ff, pend_x_ff, pend_y_ff, pend_rx2_ff;
   logic                           out_valid_ff, out_done_ff, out_last_ff;
   logic [PW-1:0]                  out_x_ff, out_y_ff;

   logic [CW-1:0]                  cx_sat, cy_sat;
   logic [RW-1:0]                  rx_sat, ry_sat;
   logic [mer_pkg::MUL_A_W-1:0]    mul_a;
   logic [mer_pkg::MUL_B_W-1:0]    mul_b;
   logic [mer_pkg::PROD_W-1:0]     product;
   logic [XW:0]                    t_val;
   logic [RW-1:0]                  ym1_mag;
   logic signed [TW-1:0]           two_rx2, two_ry2;
   logic signed [DW-1:0]           prod_ext, rx2_ext, ry2_ext, term_ext;
   logic signed [TW+1:0]           term;
   logic [PW-1:0]                  cx_p, cy_p, hx_p, hy_p, beat_x, beat_y;

   assign cx_sat = (32'(center_x) > mer_pkg::COORD_MAX) ? CW'(mer_pkg::COORD_MAX) : center_x;
   assign cy_sat = (32'(center_y) > mer_pkg::COORD_MAX) ? CW'(mer_pkg::COORD_MAX) : center_y;
   assign rx_sat = (32'(radius_x) > mer_pkg::RADIUS_MAX) ? RW'(mer_pkg::RADIUS_MAX) : radius_x;
   assign ry_sat = (32'(radius_y) > mer_pkg::RADIUS_MAX) ? RW'(mer_pkg::RADIUS_MAX) : radius_y;

   assign t_val   = {pos_x_ff, 1'b1};
   assign ym1_mag = (pos_y_ff == '0) ? RW'(1) : RW'(pos_y_ff - YW'(1));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_op)
         mer_pkg::MUL_RX2: begin
            mul_a = mer_pkg::MUL_A_W'(rx_ff);
            mul_b = mer_pkg::MUL_B_W'(rx_ff);
         end
         mer_pkg::MUL_RY2: begin
            mul_a = mer_pkg::MUL_A_W'(ry_ff);
            mul_b = mer_pkg::MUL_B_W'(ry_ff);
         end
         mer_pkg::MUL_RX2RY: begin
            mul_a = mer_pkg::MUL_A_W'(rx2_ff);
            mul_b = mer_pkg::MUL_B_W'(ry_ff);
         end
         mer_pkg::MUL_TT: begin
            mul_a = mer_pkg::MUL_A_W'(t_val);
            mul_b = mer_pkg::MUL_B_W'(t_val);
         end
         mer_pkg::MUL_YY: begin
            mul_a = mer_pkg::MUL_A_W'(ym1_mag);
            mul_b = mer_pkg::MUL_B_W'(ym1_mag);
         end
         mer_pkg::MUL_TTRY2: begin
            mul_a = tt_ff;
            mul_b = ry2_ff;
         end
         mer_pkg::MUL_YYRX2: begin
            mul_a = mer_pkg::MUL_A_W'(yy_ff);
            mul_b = rx2_ff;
         end
         mer_pkg::MUL_RX2RY2: begin
            mul_a = mer_pkg::MUL_A_W'(rx2_ff);
            mul_b = ry2_ff;
         end
         default: begin
         end
      endcase
   end

   assign product = mul_a * mul_b;

   assign two_rx2  = TW'({rx2_ff, 1'b0});
   assign two_ry2  = TW'({ry2_ff, 1'b0});
   assign prod_ext = DW'(prod_ff);
   assign rx2_ext  = DW'(rx2_ff);
   assign ry2_ext  = DW'(ry2_ff);

   assign term = (pend_x_ff ? {{2{px_ff[TW-1]}}, px_ff} : '0)
               - (pend_y_ff ? {{2{py_ff[TW-1]}}, py_ff} : '0)
               + (pend_rx2_ff ? (TW+2)'(rx2_ff) : (TW+2)'(ry2_ff));
   assign term_ext = {{(DW-TW-2){term[TW+1]}}, term};

   always_ff @(posedge clock) begin
      if (cmd.load_geom) begin
         cx_ff    <= cx_sat;
         cy_ff    <= cy_sat;
         rx_ff    <= rx_sat;
         ry_ff    <= ry_sat;
         pos_x_ff <= '0;
         pos_y_ff <= YW'(ry_sat);
      end else if (cmd.step) begin
         pos_x_ff <= pos_x_ff + XW'(cmd.step_x);
         pos_y_ff <= pos_y_ff - YW'(cmd.step_y);
      end

      unique case (cmd.mul_op) inside
         mer_pkg::MUL_RX2: rx2_ff <= product[SW-1:0];
         mer_pkg::MUL_RY2: ry2_ff <= product[SW-1:0];
         mer_pkg::MUL_TT:  tt_ff  <= product[mer_pkg::TT_W-1:0];
         mer_pkg::MUL_YY:  yy_ff  <= product[SW-1:0];
         mer_pkg::MUL_RX2RY, mer_pkg::MUL_TTRY2, mer_pkg::MUL_YYRX2,
         mer_pkg::MUL_RX2RY2: prod_ff <= product;
         default: begin
         end
      endcase

      if (cmd.step) begin
         hold_x_ff   <= pos_x_ff;
         hold_y_ff   <= pos_y_ff;
         pend_x_ff   <= cmd.step_x;
         pend_y_ff   <= cmd.step_y;
         pend_rx2_ff <= cmd.step_rx2;
         if (cmd.step_x) begin
            px_ff <= px_ff + two_ry2;
         end
         if (cmd.step_y) begin
            py_ff <= py_ff - two_rx2;
         end
      end else if (cmd.dec_op == mer_pkg::DEC_INIT) begin
         px_ff <= '0;
         py_ff <= TW'({prod_ff, 1'b0});
      end

      unique case (cmd.dec_op)
         mer_pkg::DEC_INIT: dec_ff <= (ry2_ext <<< 2) - (prod_ext <<< 2) + rx2_ext;
         mer_pkg::DEC_LOAD: dec_ff <= prod_ext;
         mer_pkg::DEC_ADD4: dec_ff <= dec_ff + (prod_ext <<< 2);
         mer_pkg::DEC_SUB4: dec_ff <= dec_ff - (prod_ext <<< 2);
         default: begin
            if (pend_valid_ff) begin
               dec_ff <= dec_ff + (term_ext <<< 2);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= cmd.step;
      end
   end

   assign cx_p   = PW'(cx_ff);
   assign cy_p   = PW'(cy_ff);
   assign hx_p   = PW'(hold_x_ff);
   assign hy_p   = {{(PW-YW){hold_y_ff[YW-1]}}, hold_y_ff};
   assign beat_x = cmd.beat[0] ? cx_p - hx_p : cx_p + hx_p;
   assign beat_y = cmd.beat[1] ? cy_p - hy_p : cy_p + hy_p;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_beat || cmd.load_done) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_beat) begin
         out_x_ff    <= beat_x;
         out_y_ff    <= beat_y;
         out_done_ff <= 1'b0;
         out_last_ff <= &cmd.beat;
      end else if (cmd.load_done) begin
         out_x_ff    <= '0;
         out_y_ff    <= '0;
         out_done_ff <= 1'b1;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign point_x    = out_x_ff;
   assign point_y    = out_y_ff;
   assign done_res   = out_done_ff;
   assign last       = out_last_ff;

   assign status.y_pos    = !pos_y_ff[YW-1] && (pos_y_ff != '0);
   assign status.y_neg    = pos_y_ff[YW-1];
   assign status.r1_below = (px_ff < py_ff);
   assign status.dec_neg  = dec_ff[DW-1];
   assign status.dec_zero = (dec_ff == '0);
   assign status.out_free = !out_valid_ff || rsp_tready;

endmodule

// ----- rtl/core/midpoint_ellipse_rasterizer.sv -----
// Step beat: four points, loaded into the output register in the emit state, one point
// per cycle while the output is free; the next request is taken with the last point.
// Step that crosses into region two: states T1 to T6 on the shared multiplier first.
// Begin beat: states B1 to B4, no result. Step after the end: one done point.
// Synchronous active-high reset clears the sequencer, the region and the output valid;
// after reset a step yields the done point.
module midpoint_ellipse_rasterizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // center_x[9:0], center_y[19:10], radius_x[28:20], radius_y[37:29], zero pad
   input  logic [mer_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // point_x[11:0], point_y[23:12]
   output logic [mer_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // done_res
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int CW = mer_pkg::CENTER_W;
   localparam int RW = mer_pkg::RADIUS_W;

   mer_pkg::dp_cmd_type                   cmd;
   mer_pkg::dp_status_type                status;
   logic signed [mer_pkg::POINT_W-1:0]    point_x, point_y;

   mer_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   mer_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .center_x   (req_tdata[CW-1:0]),
      .center_y   (req_tdata[2*CW-1:CW]),
      .radius_x   (req_tdata[2*CW+RW-1:2*CW]),
      .radius_y   (req_tdata[2*CW+2*RW-1:2*CW+RW]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .point_x    (point_x),
      .point_y    (point_y),
      .done_res   (rsp_tuser),
      .last       (rsp_tlast)
   );

   assign rsp_tdata = {point_y, point_x};

endmodule
